@@ rtl/core/bhpq_pkg.sv @@
// shared constants, types and helper functions of the binary heap priority queue
package bhpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_W     = 32;
    localparam int OCC_W     = 7;
    localparam int LEVELS    = $clog2(CAPACITY + 1);
    localparam int CNT_W     = LEVELS;
    localparam int EXT_W     = CNT_W + 1;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int IDX_W     = LEVELS - 1;
    localparam int ROW_DEPTH = 1 << IDX_W;
    localparam int POS_W     = $clog2(CAPACITY);

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        WS_CARRY = 2'd0,
        WS_UP    = 2'd1,
        WS_DOWN  = 2'd2
    } wsrc_t;

    typedef struct packed {
        logic             rd_en;
        logic             rd_pair;
        logic             rd_root;
        logic [LVL_W-1:0] rd_lvl;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [LVL_W-1:0] wr_lvl;
        logic [IDX_W-1:0] wr_addr;
        wsrc_t            wr_src;
        logic             vld_b;
    } cell_cmd_t;

    typedef struct packed {
        logic [KEY_W-1:0] rd_a;
        logic [KEY_W-1:0] rd_b;
        logic [KEY_W-1:0] best;
        logic             win;
        logic             pick_b;
        logic             up_win;
    } cell_res_t;

    typedef struct packed {
        logic [KEY_W-1:0] root_value;
        status_t          status;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    // strict win of a over b, signed
    function automatic logic beats(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
                                   input logic order_min);
        logic ret;
        if (order_min)
        begin
            ret = $signed(a) < $signed(b);
        end
        else
        begin
            ret = $signed(a) > $signed(b);
        end
        return ret;
    endfunction

    // heap level of a position
    function automatic logic [LVL_W-1:0] lvl_of(input logic [CNT_W-1:0] pos);
        logic [CNT_W-1:0] p1;
        logic [LVL_W-1:0] lvl;
        p1  = pos + CNT_W'(1);
        lvl = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (p1[i])
            begin
                lvl = LVL_W'(i);
            end
        end
        return lvl;
    endfunction

    // index of a position within its level
    function automatic logic [IDX_W-1:0] idx_of(input logic [CNT_W-1:0] pos,
                                                 input logic [LVL_W-1:0] lvl);
        logic [CNT_W-1:0] p1;
        p1 = pos + CNT_W'(1);
        return IDX_W'(p1 ^ (CNT_W'(1) << lvl));
    endfunction

endpackage

@@ rtl/core/bhpq_cell.sv @@
// one heap level: its key memory, registered reads and the compare against the carried key
module bhpq_cell (
    input  logic                                clk,
    input  logic [bhpq_pkg::LVL_W-1:0]          lvl_id,
    input  bhpq_pkg::cell_cmd_t                 cmd,
    input  logic                                order_min,
    input  logic [bhpq_pkg::KEY_W-1:0]          carry,
    input  logic [bhpq_pkg::KEY_W-1:0]          up_word,
    input  logic [bhpq_pkg::KEY_W-1:0]          dn_word,
    output bhpq_pkg::cell_res_t                 res
);

    logic [bhpq_pkg::KEY_W-1:0] mem [bhpq_pkg::ROW_DEPTH];
    logic [bhpq_pkg::KEY_W-1:0] rd_a_reg;
    logic [bhpq_pkg::KEY_W-1:0] rd_b_reg;
    logic [bhpq_pkg::KEY_W-1:0] wr_data;
    logic [bhpq_pkg::KEY_W-1:0] best_a;
    logic [bhpq_pkg::IDX_W-1:0] addr_b;
    logic                       sel_rd;
    logic                       sel_b;
    logic                       sel_wr;
    logic                       win_a;
    logic                       win_b;

    assign sel_rd = cmd.rd_en && (cmd.rd_lvl == lvl_id);
    assign sel_b  = (sel_rd && cmd.rd_pair) || (cmd.rd_root && (lvl_id == '0));
    assign addr_b = cmd.rd_root ? '0 : (cmd.rd_addr | bhpq_pkg::IDX_W'(1));
    assign sel_wr = cmd.wr_en && (cmd.wr_lvl == lvl_id);

    always_comb
    begin
        case (cmd.wr_src)
            bhpq_pkg::WS_UP:   wr_data = up_word;
            bhpq_pkg::WS_DOWN: wr_data = dn_word;
            default:           wr_data = carry;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sel_wr)
        begin
            mem[cmd.wr_addr] <= wr_data;
        end
        if (sel_rd)
        begin
            rd_a_reg <= mem[cmd.rd_addr];
        end
        if (sel_b)
        begin
            rd_b_reg <= mem[addr_b];
        end
    end

    // left child wins ties, a child must strictly beat to move up
    assign win_a  = bhpq_pkg::beats(rd_a_reg, carry, order_min);
    assign best_a = win_a ? rd_a_reg : carry;
    assign win_b  = cmd.vld_b && bhpq_pkg::beats(rd_b_reg, best_a, order_min);

    assign res.rd_a   = rd_a_reg;
    assign res.rd_b   = rd_b_reg;
    assign res.best   = win_b ? rd_b_reg : best_a;
    assign res.win    = win_a || win_b;
    assign res.pick_b = win_b;
    assign res.up_win = bhpq_pkg::beats(carry, rd_a_reg, order_min);

endmodule

@@ rtl/core/bhpq_ctrl.sv @@
// sequencer: entry count, sift position and the level commands for the cell row
module bhpq_ctrl (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         req_valid,
    input  logic                                         req_cmd,
    input  logic [bhpq_pkg::KEY_W-1:0]                   req_key,
    output logic                                         busy,
    input  logic                                         out_free,
    input  bhpq_pkg::cell_res_t [bhpq_pkg::LEVELS-1:0]   res,
    output bhpq_pkg::cell_cmd_t                          cell_cmd,
    output logic [bhpq_pkg::KEY_W-1:0]                   carry,
    output logic                                         fin,
    output bhpq_pkg::rsp_t                               rsp
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_UP_CMP  = 6'b000010,
        S_DN_LOAD = 6'b000100,
        S_DN_CMP  = 6'b001000,
        S_PUT     = 6'b010000,
        S_DONE    = 6'b100000
    } state_t;

    state_t                      state_reg,  state_next;
    logic [bhpq_pkg::CNT_W-1:0]  count_reg,  count_next;
    logic [bhpq_pkg::LVL_W-1:0]  lvl_reg,    lvl_next;
    logic [bhpq_pkg::IDX_W-1:0]  idx_reg,    idx_next;
    logic [bhpq_pkg::POS_W-1:0]  pos_reg,    pos_next;
    logic [bhpq_pkg::KEY_W-1:0]  carry_reg,  carry_next;
    logic [bhpq_pkg::KEY_W-1:0]  root_reg,   root_next;
    bhpq_pkg::status_t           status_reg, status_next;

    logic [bhpq_pkg::LVL_W-1:0]  tail_lvl;
    logic [bhpq_pkg::IDX_W-1:0]  tail_idx;
    logic [bhpq_pkg::CNT_W-1:0]  last_pos;
    logic [bhpq_pkg::LVL_W-1:0]  last_lvl;
    logic [bhpq_pkg::IDX_W-1:0]  last_idx;
    logic [bhpq_pkg::LVL_W-1:0]  lvl_up;
    logic [bhpq_pkg::LVL_W-1:0]  lvl_dn;
    logic [bhpq_pkg::EXT_W-1:0]  left_pos;
    logic [bhpq_pkg::EXT_W-1:0]  right_pos;
    logic [bhpq_pkg::EXT_W-1:0]  child_pos;
    logic [bhpq_pkg::EXT_W-1:0]  grand_left;
    logic [bhpq_pkg::EXT_W-1:0]  count_ext;
    bhpq_pkg::cell_res_t         res_up;
    bhpq_pkg::cell_res_t         res_dn;

    assign tail_lvl = bhpq_pkg::lvl_of(count_reg);
    assign tail_idx = bhpq_pkg::idx_of(count_reg, tail_lvl);
    assign last_pos = count_reg - bhpq_pkg::CNT_W'(1);
    assign last_lvl = bhpq_pkg::lvl_of(last_pos);
    assign last_idx = bhpq_pkg::idx_of(last_pos, last_lvl);

    assign lvl_up = lvl_reg - bhpq_pkg::LVL_W'(1);
    assign lvl_dn = lvl_reg + bhpq_pkg::LVL_W'(1);
    assign res_up = res[lvl_up];
    assign res_dn = res[lvl_dn];

    assign count_ext  = bhpq_pkg::EXT_W'(count_reg);
    assign left_pos   = bhpq_pkg::EXT_W'({pos_reg, 1'b0}) + bhpq_pkg::EXT_W'(1);
    assign right_pos  = left_pos + bhpq_pkg::EXT_W'(1);
    assign child_pos  = left_pos + bhpq_pkg::EXT_W'(res_dn.pick_b);
    assign grand_left = bhpq_pkg::EXT_W'({child_pos[bhpq_pkg::POS_W-1:0], 1'b0})
                        + bhpq_pkg::EXT_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lvl_next    = lvl_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        carry_next  = carry_reg;
        root_next   = root_reg;
        status_next = status_reg;
        cell_cmd    = '0;
        fin         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    root_next = '0;
                    if (req_cmd == bhpq_pkg::CMD_INSERT)
                    begin
                        if (count_reg == bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY))
                        begin
                            status_next = bhpq_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            carry_next  = req_key;
                            count_next  = count_reg + bhpq_pkg::CNT_W'(1);
                            status_next = bhpq_pkg::ST_INSERTED;
                            lvl_next    = tail_lvl;
                            idx_next    = tail_idx;
                            if (count_reg == '0)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                cell_cmd.rd_en   = 1'b1;
                                cell_cmd.rd_lvl  = tail_lvl - bhpq_pkg::LVL_W'(1);
                                cell_cmd.rd_addr = tail_idx >> 1;
                                state_next       = S_UP_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bhpq_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            // fetch root and last entry together
                            count_next       = last_pos;
                            status_next      = bhpq_pkg::ST_REMOVED;
                            lvl_next         = last_lvl;
                            idx_next         = last_idx;
                            cell_cmd.rd_en   = 1'b1;
                            cell_cmd.rd_root = 1'b1;
                            cell_cmd.rd_lvl  = last_lvl;
                            cell_cmd.rd_addr = last_idx;
                            state_next       = S_DN_LOAD;
                        end
                    end
                end
            end

            S_DN_LOAD:
            begin
                root_next  = res[0].rd_b;
                carry_next = res[lvl_reg].rd_a;
                lvl_next   = '0;
                idx_next   = '0;
                pos_next   = '0;
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg > bhpq_pkg::CNT_W'(1))
                begin
                    cell_cmd.rd_en   = 1'b1;
                    cell_cmd.rd_pair = 1'b1;
                    cell_cmd.rd_lvl  = bhpq_pkg::LVL_W'(1);
                    cell_cmd.rd_addr = '0;
                    state_next       = S_DN_CMP;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_UP_CMP:
            begin
                cell_cmd.wr_en   = 1'b1;
                cell_cmd.wr_lvl  = lvl_reg;
                cell_cmd.wr_addr = idx_reg;
                if (res_up.up_win)
                begin
                    // parent moves down one level, key climbs
                    cell_cmd.wr_src = bhpq_pkg::WS_UP;
                    lvl_next        = lvl_up;
                    idx_next        = idx_reg >> 1;
                    if (lvl_up == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        cell_cmd.rd_en   = 1'b1;
                        cell_cmd.rd_lvl  = lvl_up - bhpq_pkg::LVL_W'(1);
                        cell_cmd.rd_addr = idx_reg >> 2;
                    end
                end
                else
                begin
                    cell_cmd.wr_src = bhpq_pkg::WS_CARRY;
                    state_next      = S_DONE;
                end
            end

            S_DN_CMP:
            begin
                cell_cmd.vld_b   = right_pos < count_ext;
                cell_cmd.wr_en   = 1'b1;
                cell_cmd.wr_lvl  = lvl_reg;
                cell_cmd.wr_addr = idx_reg;
                if (res_dn.win)
                begin
                    // winning child moves up one level
                    cell_cmd.wr_src = bhpq_pkg::WS_DOWN;
                    lvl_next        = lvl_dn;
                    idx_next        = bhpq_pkg::IDX_W'({idx_reg, res_dn.pick_b});
                    pos_next        = child_pos[bhpq_pkg::POS_W-1:0];
                    if (grand_left < count_ext)
                    begin
                        cell_cmd.rd_en   = 1'b1;
                        cell_cmd.rd_pair = 1'b1;
                        cell_cmd.rd_lvl  = lvl_dn + bhpq_pkg::LVL_W'(1);
                        cell_cmd.rd_addr = bhpq_pkg::IDX_W'({idx_reg, res_dn.pick_b, 1'b0});
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    cell_cmd.wr_src = bhpq_pkg::WS_CARRY;
                    state_next      = S_DONE;
                end
            end

            S_PUT:
            begin
                cell_cmd.wr_en   = 1'b1;
                cell_cmd.wr_lvl  = lvl_reg;
                cell_cmd.wr_addr = idx_reg;
                cell_cmd.wr_src  = bhpq_pkg::WS_CARRY;
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg    <= lvl_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        carry_reg  <= carry_next;
        root_reg   <= root_next;
        status_reg <= status_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign carry          = carry_reg;
    assign rsp.root_value = root_reg;
    assign rsp.status     = status_reg;
    assign rsp.occupancy  = bhpq_pkg::OCC_W'(count_reg);

endmodule

@@ rtl/core/binary_heap_priority_queue.sv @@
// top level of the binary heap priority queue: level cell row, sequencer, response register
// insert: request side stalled while the new key sifts up, remove: while the last entry sifts down
// a full insert or an empty remove skips the sift; the response is registered as the done state finds the output free
// each sift step covers one heap level per cycle: a registered read in one level cell and a compare
// reset clears the entry count, order bit and control state; level memories are left as they are
module binary_heap_priority_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic                               cmd,
    input  logic signed [bhpq_pkg::KEY_W-1:0]  key,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic signed [bhpq_pkg::KEY_W-1:0]  root_value,
    output logic [1:0]                         status,
    output logic [bhpq_pkg::OCC_W-1:0]         occupancy
);

    logic                                       order_min_reg;
    logic                                       rsp_valid_reg;
    bhpq_pkg::rsp_t                             rsp_reg;
    bhpq_pkg::rsp_t                             rsp_new;
    bhpq_pkg::cell_cmd_t                        cell_cmd;
    bhpq_pkg::cell_res_t [bhpq_pkg::LEVELS-1:0] cell_res;
    logic [bhpq_pkg::KEY_W-1:0]                 carry;
    logic [bhpq_pkg::KEY_W-1:0]                 up_word [bhpq_pkg::LEVELS];
    logic [bhpq_pkg::KEY_W-1:0]                 dn_word [bhpq_pkg::LEVELS];
    logic                                       busy;
    logic                                       fin;
    logic                                       out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_min_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            order_min_reg <= cfg_wdata;
        end
    end

    bhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (cmd),
        .req_key   (key),
        .busy      (busy),
        .out_free  (out_free),
        .res       (cell_res),
        .cell_cmd  (cell_cmd),
        .carry     (carry),
        .fin       (fin),
        .rsp       (rsp_new)
    );

    for (genvar g = 0; g < bhpq_pkg::LEVELS; g++)
    begin : g_level
        if (g == 0)
        begin : g_top_word
            assign up_word[g] = '0;
        end
        else
        begin : g_up_word
            assign up_word[g] = cell_res[g-1].rd_a;
        end

        if (g == bhpq_pkg::LEVELS - 1)
        begin : g_bottom_word
            assign dn_word[g] = '0;
        end
        else
        begin : g_dn_word
            assign dn_word[g] = cell_res[g+1].best;
        end

        bhpq_cell u_cell (
            .clk       (clk),
            .lvl_id    (bhpq_pkg::LVL_W'(g)),
            .cmd       (cell_cmd),
            .order_min (order_min_reg),
            .carry     (carry),
            .up_word   (up_word[g]),
            .dn_word   (dn_word[g]),
            .res       (cell_res[g])
        );
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fin)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            rsp_reg <= rsp_new;
        end
    end

    assign req_stall  = busy;
    assign rsp_valid  = rsp_valid_reg;
    assign root_value = rsp_reg.root_value;
    assign status     = rsp_reg.status;
    assign occupancy  = rsp_reg.occupancy;

`ifndef SYNTHESIS
    a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while another is in flight");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result loaded with no request in flight");

    a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == bhpq_pkg::ST_FULL))
        |-> (occupancy == bhpq_pkg::OCC_W'(bhpq_pkg::CAPACITY)))
        else $error("full status without full occupancy");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == bhpq_pkg::ST_EMPTY))
        |-> ((occupancy == '0) && (root_value == '0)))
        else $error("empty status with keys or value");
`endif

endmodule
